[sv/emg_pkg.sv]
// ----------------------------------------------------------------------------
// emg_pkg
// shared types, codes and default sizes of the id map embedding gather block
// ----------------------------------------------------------------------------
package emg_pkg;

	localparam int MAX_SPLITS_DEF     = 8;
	localparam int ROWS_PER_SPLIT_DEF = 256;
	localparam int MAX_DIM_DEF        = 32;
	localparam int MAP_ENTRIES_DEF    = 2048;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN     = 2'd1;

	localparam logic [3:0] SPLIT_COUNT_RST = 4'd1;
	localparam logic [5:0] ROW_LEN_RST     = 6'd16;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_WRITE  = 2'd2,
		MODE_LOOKUP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_WORD      = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BAD_SPLIT = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MOP_CLEAR  = 2'd0,
		MOP_INSERT = 2'd1,
		MOP_LOOKUP = 2'd2
	} map_op_t;

	typedef enum logic [2:0] {
		MR_INSERTED  = 3'd0,
		MR_DUPLICATE = 3'd1,
		MR_FULL      = 3'd2,
		MR_FOUND     = 3'd3,
		MR_NOT_FOUND = 3'd4
	} map_res_t;

	typedef struct packed {
		logic    valid;
		map_op_t op;
	} map_req_t;

	typedef struct packed {
		logic     valid;
		map_res_t res;
	} map_rsp_t;

endpackage

[sv/id_map_embedding_gather.sv]
// ----------------------------------------------------------------------------
// id_map_embedding_gather
// maps 64-bit ids to embedding rows and streams the row words on lookup
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes one word per command: clear map,
// insert id, write embedding word or look up id. output channel
// (out_valid/out_ready) returns status words; a lookup of a known id returns
// one word per row position up to the row length, with last on the final one.
// config channel (cfg_valid/cfg_ready, always ready) writes the split count
// and the row length.
// one command at a time. a word write goes to the row store when accepted.
// an insert or lookup probes the id map one entry per cycle from the hashed
// slot, at most MAP_ENTRIES entries. a lookup hit then streams one word per
// cycle from the row memory read port while the receiver takes them.
// a clear sweeps all MAP_ENTRIES map entries (2048 by default).
// after reset the same sweep runs before in_ready rises; the row store is
// not cleared. when the receiver stalls the output register holds its word,
// reads stop and in_ready stays low until the command's last word is loaded
// into the output register.
// ----------------------------------------------------------------------------
module id_map_embedding_gather #(
	parameter int MAX_SPLITS     = emg_pkg::MAX_SPLITS_DEF,
	parameter int ROWS_PER_SPLIT = emg_pkg::ROWS_PER_SPLIT_DEF,
	parameter int MAX_DIM        = emg_pkg::MAX_DIM_DEF,
	parameter int MAP_ENTRIES    = emg_pkg::MAP_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     mode,
	input  logic signed [63:0]             key_id,
	input  logic [2:0]                     split_index,
	input  logic [7:0]                     row_index,
	input  logic [4:0]                     column_index,
	input  logic [31:0]                    element_bits,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [31:0]                    element_out,
	output logic [4:0]                     element_column,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [emg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [emg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int LOCS      = MAX_SPLITS * ROWS_PER_SPLIT;
	localparam int ROW_WORDS = LOCS * MAX_DIM;
	localparam int LOC_W     = (LOCS > 1) ? $clog2(LOCS) : 1;
	localparam int RA_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int SPL_W     = $clog2(MAX_SPLITS + 1);

	typedef enum logic [3:0] {
		T_IDLE   = 4'b0001,
		T_MAP    = 4'b0010,
		T_STREAM = 4'b0100,
		T_ONE    = 4'b1000
	} tstate_t;

	tstate_t           state_q;
	logic [3:0]        split_count_q;
	logic [5:0]        row_len_q;
	emg_pkg::status_t  one_status_q;
	logic [RA_W-1:0]   base_q;
	logic [DIM_W-1:0]  dim_q;
	logic [DIM_W-1:0]  col_issue_q;
	logic              rd_pend_s1;
	logic [DIM_W-1:0]  col_s1;
	logic              out_valid_q;
	emg_pkg::status_t  out_status_q;
	logic [31:0]       out_word_q;
	logic [4:0]        out_col_q;
	logic              out_last_q;

	logic [SPL_W-1:0]  eff_splits;
	logic [DIM_W-1:0]  eff_dim;
	logic              loc_ok;
	logic              col_ok;
	logic [LOC_W-1:0]  in_loc;
	logic              accept;
	logic              can_load;
	logic              issue;
	logic              load_word;
	logic              load_one;
	logic              word_last;
	logic [31:0]       row_rd_data;
	logic              row_wr_en;
	logic [RA_W-1:0]   row_wr_addr;
	logic [RA_W-1:0]   row_rd_addr;

	emg_pkg::map_req_t map_req;
	emg_pkg::map_rsp_t map_rsp;
	logic              map_ready;
	logic [LOC_W-1:0]  map_loc;

	// register clamping
	always_comb begin
		if (split_count_q == '0) begin
			eff_splits = SPL_W'(1);
		end else if (32'(split_count_q) > 32'(MAX_SPLITS)) begin
			eff_splits = SPL_W'(MAX_SPLITS);
		end else begin
			eff_splits = SPL_W'(split_count_q);
		end
		if (row_len_q == '0) begin
			eff_dim = DIM_W'(1);
		end else if (32'(row_len_q) > 32'(MAX_DIM)) begin
			eff_dim = DIM_W'(MAX_DIM);
		end else begin
			eff_dim = DIM_W'(row_len_q);
		end
	end

	assign loc_ok = (32'(split_index) < 32'(eff_splits)) &&
		(32'(row_index) < 32'(ROWS_PER_SPLIT));
	assign col_ok = 32'(column_index) < 32'(MAX_DIM);
	assign in_loc = LOC_W'(32'(split_index) * 32'(ROWS_PER_SPLIT) + 32'(row_index));

	assign in_ready  = (state_q == T_IDLE) && map_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		map_req.valid = 1'b0;
		map_req.op    = emg_pkg::MOP_LOOKUP;
		if (accept) begin
			unique case (emg_pkg::mode_t'(mode))
				emg_pkg::MODE_CLEAR: begin
					map_req.valid = 1'b1;
					map_req.op    = emg_pkg::MOP_CLEAR;
				end
				emg_pkg::MODE_INSERT: begin
					map_req.valid = loc_ok;
					map_req.op    = emg_pkg::MOP_INSERT;
				end
				emg_pkg::MODE_LOOKUP: begin
					map_req.valid = 1'b1;
				end
				default: begin
					map_req.valid = 1'b0;
				end
			endcase
		end
	end

	assign row_wr_en   = accept && (mode == emg_pkg::MODE_WRITE) && loc_ok && col_ok;
	assign row_wr_addr = RA_W'(32'(in_loc) * 32'(MAX_DIM) + 32'(column_index));
	assign row_rd_addr = base_q + RA_W'(col_issue_q);

	assign can_load  = !out_valid_q || out_ready;
	assign issue     = (state_q == T_STREAM) && (col_issue_q < dim_q) &&
		(!rd_pend_s1 || can_load);
	assign load_word = rd_pend_s1 && can_load;
	assign load_one  = (state_q == T_ONE) && can_load;
	assign word_last = (col_s1 == dim_q - 1'b1);

	emg_map_store #(
		.MAP_ENTRIES (MAP_ENTRIES),
		.LOC_W       (LOC_W)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (map_req),
		.req_key   (key_id),
		.req_loc   (in_loc),
		.req_ready (map_ready),
		.rsp       (map_rsp),
		.rsp_loc   (map_loc)
	);

	emg_row_ram #(
		.WORDS  (ROW_WORDS),
		.ADDR_W (RA_W)
	) u_rows (
		.clk     (clk),
		.wr_en   (row_wr_en),
		.wr_addr (row_wr_addr),
		.wr_data (element_bits),
		.rd_en   (issue),
		.rd_addr (row_rd_addr),
		.rd_data (row_rd_data)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_count_q <= emg_pkg::SPLIT_COUNT_RST;
			row_len_q     <= emg_pkg::ROW_LEN_RST;
		end else if (cfg_valid) begin
			if (cfg_index == emg_pkg::CFG_SPLIT_COUNT) begin
				split_count_q <= cfg_data[3:0];
			end else if (cfg_index == emg_pkg::CFG_ROW_LEN) begin
				row_len_q <= cfg_data;
			end
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			col_issue_q <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (mode == emg_pkg::MODE_INSERT) begin
							state_q <= loc_ok ? T_MAP : T_ONE;
						end else if (mode == emg_pkg::MODE_LOOKUP) begin
							state_q <= T_MAP;
						end
					end
				end
				T_MAP: begin
					if (map_rsp.valid) begin
						col_issue_q <= '0;
						state_q     <= (map_rsp.res == emg_pkg::MR_FOUND) ? T_STREAM : T_ONE;
					end
				end
				T_STREAM: begin
					if (issue) begin
						col_issue_q <= col_issue_q + 1'b1;
						rd_pend_s1  <= 1'b1;
					end else if (load_word) begin
						rd_pend_s1 <= 1'b0;
					end
					if (load_word && word_last) begin
						state_q <= T_IDLE;
					end
				end
				T_ONE: begin
					if (can_load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			one_status_q <= emg_pkg::ST_BAD_SPLIT;
		end else if (state_q == T_MAP && map_rsp.valid) begin
			unique case (map_rsp.res)
				emg_pkg::MR_INSERTED:  one_status_q <= emg_pkg::ST_INSERTED;
				emg_pkg::MR_DUPLICATE: one_status_q <= emg_pkg::ST_DUPLICATE;
				emg_pkg::MR_FULL:      one_status_q <= emg_pkg::ST_FULL;
				default:               one_status_q <= emg_pkg::ST_NOT_FOUND;
			endcase
			base_q <= RA_W'(32'(map_loc) * 32'(MAX_DIM));
			dim_q  <= eff_dim;
		end
		if (issue) begin
			col_s1 <= col_issue_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_word || load_one) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			out_status_q <= emg_pkg::ST_WORD;
			out_word_q   <= row_rd_data;
			out_col_q    <= 5'(col_s1);
			out_last_q   <= word_last;
		end else if (load_one) begin
			out_status_q <= one_status_q;
			out_word_q   <= '0;
			out_col_q    <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign element_out    = out_word_q;
	assign element_column = out_col_q;
	assign last           = out_last_q;

	a_pend_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == T_STREAM))
		else $error("row read pending outside stream");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_STREAM) |-> (col_issue_q <= dim_q))
		else $error("row read column past row length");

	a_rsp_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		map_rsp.valid |-> (state_q == T_MAP))
		else $error("map response while not waiting");

	a_stream_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_STREAM && load_word && word_last) |=> (state_q == T_IDLE))
		else $error("stream did not end after last word");

endmodule

[sv/emg_map_store.sv]
// ----------------------------------------------------------------------------
// emg_map_store
// open-addressed id map in one synchronous memory, linear probing, clear sweep
// ----------------------------------------------------------------------------
module emg_map_store #(
	parameter int MAP_ENTRIES = emg_pkg::MAP_ENTRIES_DEF,
	parameter int LOC_W       = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  emg_pkg::map_req_t   req,
	input  logic [63:0]         req_key,
	input  logic [LOC_W-1:0]    req_loc,
	output logic                req_ready,
	output emg_pkg::map_rsp_t   rsp,
	output logic [LOC_W-1:0]    rsp_loc
);

	localparam int IDX_W  = $clog2(MAP_ENTRIES);
	localparam int CNT_W  = $clog2(MAP_ENTRIES + 1);
	localparam int NCHUNK = (64 + IDX_W - 1) / IDX_W;

	typedef struct packed {
		logic             used;
		logic [63:0]      key;
		logic [LOC_W-1:0] loc;
	} entry_t;

	typedef enum logic [2:0] {
		MS_CLEAR = 3'b001,
		MS_IDLE  = 3'b010,
		MS_PROBE = 3'b100
	} mstate_t;

	entry_t entry_mem_q [MAP_ENTRIES];
	entry_t rd_data_q;

	mstate_t           state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  probes_q;
	logic [CNT_W-1:0]  count_q;
	emg_pkg::map_op_t  op_q;
	logic [63:0]       key_q;
	logic [LOC_W-1:0]  loc_q;
	emg_pkg::map_rsp_t rsp_q;
	logic [LOC_W-1:0]  rsp_loc_q;

	logic [IDX_W-1:0] fold;
	logic [IDX_W-1:0] home;
	logic [IDX_W-1:0] idx_next;
	logic             hit;
	logic             empty;
	logic             exhausted;
	logic             probe_go;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	entry_t           wr_data;

	// xor fold of the id down to the index width
	always_comb begin
		fold = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			for (int b = 0; b < IDX_W; b++) begin
				if (c * IDX_W + b < 64) begin
					fold[b] = fold[b] ^ req_key[c * IDX_W + b];
				end
			end
		end
		if (CNT_W'(fold) >= CNT_W'(MAP_ENTRIES)) begin
			home = fold - IDX_W'(MAP_ENTRIES);
		end else begin
			home = fold;
		end
	end

	assign idx_next  = (idx_q == IDX_W'(MAP_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
	assign hit       = rd_data_q.used && (rd_data_q.key == key_q);
	assign empty     = !rd_data_q.used;
	assign exhausted = (probes_q == CNT_W'(MAP_ENTRIES - 1));
	assign probe_go  = (state_q == MS_PROBE) && !hit && !empty && !exhausted;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_next;
		if (state_q == MS_IDLE && req.valid && req.op != emg_pkg::MOP_CLEAR) begin
			rd_en   = 1'b1;
			rd_addr = home;
		end else if (probe_go) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_data.used = 1'b1;
		wr_data.key  = key_q;
		wr_data.loc  = loc_q;
		if (state_q == MS_CLEAR) begin
			wr_en        = 1'b1;
			wr_data.used = 1'b0;
		end else if (state_q == MS_PROBE && op_q == emg_pkg::MOP_INSERT && !hit && empty) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MS_CLEAR;
			idx_q     <= '0;
			probes_q  <= '0;
			count_q   <= '0;
			rsp_q     <= '{valid: 1'b0, res: emg_pkg::MR_NOT_FOUND};
		end else begin
			rsp_q.valid <= 1'b0;
			unique case (state_q)
				MS_CLEAR: begin
					if (idx_q == IDX_W'(MAP_ENTRIES - 1)) begin
						state_q <= MS_IDLE;
						count_q <= '0;
					end
					idx_q <= idx_next;
				end
				MS_IDLE: begin
					if (req.valid) begin
						if (req.op == emg_pkg::MOP_CLEAR) begin
							state_q <= MS_CLEAR;
							idx_q   <= '0;
						end else begin
							state_q  <= MS_PROBE;
							idx_q    <= home;
							probes_q <= '0;
						end
					end
				end
				MS_PROBE: begin
					if (hit) begin
						state_q     <= MS_IDLE;
						rsp_q.valid <= 1'b1;
						rsp_q.res   <= (op_q == emg_pkg::MOP_INSERT) ?
							emg_pkg::MR_DUPLICATE : emg_pkg::MR_FOUND;
					end else if (empty || exhausted) begin
						state_q     <= MS_IDLE;
						rsp_q.valid <= 1'b1;
						if (op_q != emg_pkg::MOP_INSERT) begin
							rsp_q.res <= emg_pkg::MR_NOT_FOUND;
						end else if (empty) begin
							rsp_q.res <= emg_pkg::MR_INSERTED;
							count_q   <= count_q + 1'b1;
						end else begin
							rsp_q.res <= emg_pkg::MR_FULL;
						end
					end else begin
						idx_q    <= idx_next;
						probes_q <= probes_q + 1'b1;
					end
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_IDLE && req.valid) begin
			op_q  <= req.op;
			key_q <= req_key;
			loc_q <= req_loc;
		end
		if (state_q == MS_PROBE && hit) begin
			rsp_loc_q <= rd_data_q.loc;
		end
	end

	assign req_ready = (state_q == MS_IDLE);
	assign rsp       = rsp_q;
	assign rsp_loc   = rsp_loc_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAP_ENTRIES))
		else $error("map fill count above capacity");

	a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MS_CLEAR) |=> !rsp_q.valid)
		else $error("map response during clear sweep");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_q.valid && rsp_q.res == emg_pkg::MR_INSERTED) |-> count_q != '0)
		else $error("insert reported with empty map");

endmodule

[sv/emg_row_ram.sv]
// ----------------------------------------------------------------------------
// emg_row_ram
// embedding row store, one write port and one registered read port
// ----------------------------------------------------------------------------
module emg_row_ram #(
	parameter int WORDS  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] word_mem_q [WORDS];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= word_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
